// ===== hw/rtl/srt_pkg.sv =====
// srt_pkg: sizes, codes and shared types of the sorted rank table
// used by srt_cell, srt_gather and sorted_rank_table_top; no dependencies
package srt_pkg;

   localparam int CAPACITY = 256;
   localparam int INDEX_W  = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int RANK_W   = 9;
   localparam int KEY_W    = 32;
   localparam int WIDE_W   = (RANK_W > INDEX_W + 1) ? RANK_W : INDEX_W + 1;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_DELETE  = 2'd1,
      OP_RANK    = 2'd2,
      OP_AT_RANK = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_UNUSED    = 2'd3
   } status_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic                     cmp_en;
      logic                     ins_en;
      logic                     del_en;
      logic signed [KEY_W-1:0]  score;
      logic signed [KEY_W-1:0]  id;
      logic [COUNT_W-1:0]       count;
      logic [RANK_W-1:0]        qrank;
   } srt_ctrl_type;

   // gathered answer of the whole row
   typedef struct packed {
      logic [COUNT_W-1:0]       pos;
      logic                     hit;
      logic                     pick;
      logic signed [KEY_W-1:0]  score;
      logic signed [KEY_W-1:0]  id;
   } srt_gather_type;

endpackage

// ===== hw/rtl/srt_cell.sv =====
// srt_cell: one slot of the sorted row, holding one (score, id) entry
// compares against the broadcast key and shifts toward either neighbor; uses srt_pkg
module srt_cell
   import srt_pkg::*;
(
   input  logic                    clock,
   input  srt_ctrl_type            ctrl,
   input  logic [INDEX_W-1:0]      cell_index,
   input  logic                    left_lt,
   input  logic signed [KEY_W-1:0] left_score,
   input  logic signed [KEY_W-1:0] left_id,
   input  logic signed [KEY_W-1:0] right_score,
   input  logic signed [KEY_W-1:0] right_id,
   output logic signed [KEY_W-1:0] cell_score,
   output logic signed [KEY_W-1:0] cell_id,
   output logic                    cell_lt,
   output logic                    cell_edge,
   output logic                    cell_hit,
   output logic                    cell_pick
);

   logic signed [KEY_W-1:0] score_ff, score_in;
   logic signed [KEY_W-1:0] id_ff, id_in;
   logic lt_ff, lt_in;
   logic eq_ff, eq_in;
   logic sel_ff, sel_in;
   logic valid;
   logic less;
   logic same;

   assign valid = COUNT_W'(cell_index) < ctrl.count;
   assign less  = (score_ff < ctrl.score) || ((score_ff == ctrl.score) && (id_ff < ctrl.id));
   assign same  = (score_ff == ctrl.score) && (id_ff == ctrl.id);

   always_comb begin
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      sel_in   = sel_ff;
      score_in = score_ff;
      id_in    = id_ff;
      if (ctrl.cmp_en) begin
         lt_in  = valid && less;
         eq_in  = valid && same;
         sel_in = valid && (WIDE_W'(ctrl.qrank) == WIDE_W'(cell_index) + WIDE_W'(1));
      end
      // entries at or above the insert point move up one slot
      if (ctrl.ins_en && !lt_ff) begin
         if (left_lt) begin
            score_in = ctrl.score;
            id_in    = ctrl.id;
         end else begin
            score_in = left_score;
            id_in    = left_id;
         end
      end
      // entries from the removed one upward move down one slot
      if (ctrl.del_en && !lt_ff) begin
         score_in = right_score;
         id_in    = right_id;
      end
   end

   always_ff @(posedge clock) begin
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
      sel_ff   <= sel_in;
      score_ff <= score_in;
      id_ff    <= id_in;
   end

   assign cell_score = score_ff;
   assign cell_id    = id_ff;
   assign cell_lt    = lt_ff;
   assign cell_edge  = left_lt && !lt_ff;
   assign cell_hit   = left_lt && !lt_ff && eq_ff;
   assign cell_pick  = sel_ff;

endmodule

// ===== hw/rtl/srt_gather.sv =====
// srt_gather: collects the per-cell flags of the row into one answer
// encodes the insert point, detects a key match and selects the ranked entry; uses srt_pkg
module srt_gather
   import srt_pkg::*;
(
   input  logic [CAPACITY-1:0]      edge_vec,
   input  logic                     last_lt,
   input  logic [CAPACITY-1:0]      hit_vec,
   input  logic [CAPACITY-1:0]      pick_vec,
   input  logic signed [KEY_W-1:0]  score_vec [CAPACITY],
   input  logic signed [KEY_W-1:0]  id_vec [CAPACITY],
   output srt_gather_type           gather
);

   // edge_vec is one-hot (or empty when every cell lies below the key)
   always_comb begin
      gather.pos   = last_lt ? COUNT_W'(CAPACITY) : '0;
      gather.hit   = |hit_vec;
      gather.pick  = |pick_vec;
      gather.score = '0;
      gather.id    = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if (edge_vec[k]) begin
            gather.pos = gather.pos | COUNT_W'(k);
         end
         if (pick_vec[k]) begin
            gather.score = gather.score | score_vec[k];
            gather.id    = gather.id | id_vec[k];
         end
      end
   end

endmodule

// ===== hw/rtl/sorted_rank_table_top.sv =====
// sorted_rank_table_top: sorted set of (score, id) entries with rank lookup
// holds a row of srt_cell slots and one srt_gather; uses srt_pkg
//
// Requests arrive on the req_ stream: req_tuser carries the operation (insert, delete,
// rank of key, entry at rank), req_tdata the key and the queried rank. Each request
// gives exactly one response on the rsp_ stream: status in rsp_tuser, rank, entry and
// the number of entries held in rsp_tdata.
// A request passes through S_CMP, in which every cell compares its entry with the key
// in parallel, and then S_UPD, in which the flags are gathered (insert point, match,
// selected entry) and the row shifts. The response is registered at the end of S_UPD,
// and a new request is taken in that same cycle, so the next request can be accepted
// while the previous one is completing its update.
// The response register keeps the last result while the receiver stalls; the next
// request still goes through its compare cycle, and its update waits until the
// response register is free.
// Reset empties the table (entry count zero) and drops any pending response; stored
// entries are not cleared, the count alone marks which cells hold data.
module sorted_rank_table_top
   import srt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,    // op
   input  logic [REQ_DATA_W-1:0] req_tdata,    // key_score, key_id, query_rank, zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_tuser,    // status
   output logic [RSP_DATA_W-1:0] rsp_tdata     // found_rank, found_score, found_id,
                                               // entry_total, zero pad
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_UPD
   } state_type;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic signed [KEY_W-1:0] score_ff, score_in;
   logic signed [KEY_W-1:0] id_ff, id_in;
   logic [RANK_W-1:0]       qrank_ff, qrank_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]              rsp_tuser_ff, rsp_tuser_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   srt_ctrl_type            ctrl;
   srt_gather_type          gather;
   logic                    accept;
   logic                    finish;
   logic                    full;
   status_type              status;
   logic [RANK_W-1:0]       rank;
   logic signed [KEY_W-1:0] out_score;
   logic signed [KEY_W-1:0] out_id;
   logic [COUNT_W-1:0]      count_next;

   logic [CAPACITY-1:0]     lt_vec;
   logic [CAPACITY-1:0]     edge_vec;
   logic [CAPACITY-1:0]     hit_vec;
   logic [CAPACITY-1:0]     pick_vec;
   logic signed [KEY_W-1:0] score_vec [CAPACITY];
   logic signed [KEY_W-1:0] id_vec [CAPACITY];

   assign full       = count_ff >= COUNT_W'(CAPACITY);
   assign finish     = (state_ff == S_UPD) && (!rsp_tvalid_ff || rsp_tready);
   assign req_tready = (state_ff == S_IDLE) || finish;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      ctrl.cmp_en = (state_ff == S_CMP);
      ctrl.ins_en = finish && (op_ff == OP_INSERT) && !full;
      ctrl.del_en = finish && (op_ff == OP_DELETE) && gather.hit;
      ctrl.score  = score_ff;
      ctrl.id     = id_ff;
      ctrl.count  = count_ff;
      ctrl.qrank  = qrank_ff;
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic                    left_lt;
      logic signed [KEY_W-1:0] left_score;
      logic signed [KEY_W-1:0] left_id;
      logic signed [KEY_W-1:0] right_score;
      logic signed [KEY_W-1:0] right_id;

      if (g == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_score = score_ff;
         assign left_id    = id_ff;
      end else begin : g_inner
         assign left_lt    = lt_vec[g-1];
         assign left_score = score_vec[g-1];
         assign left_id    = id_vec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_score = score_vec[g];
         assign right_id    = id_vec[g];
      end else begin : g_body
         assign right_score = score_vec[g+1];
         assign right_id    = id_vec[g+1];
      end

      srt_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_index  (INDEX_W'(g)),
         .left_lt     (left_lt),
         .left_score  (left_score),
         .left_id     (left_id),
         .right_score (right_score),
         .right_id    (right_id),
         .cell_score  (score_vec[g]),
         .cell_id     (id_vec[g]),
         .cell_lt     (lt_vec[g]),
         .cell_edge   (edge_vec[g]),
         .cell_hit    (hit_vec[g]),
         .cell_pick   (pick_vec[g])
      );
   end

   srt_gather u_gather (
      .edge_vec  (edge_vec),
      .last_lt   (lt_vec[CAPACITY-1]),
      .hit_vec   (hit_vec),
      .pick_vec  (pick_vec),
      .score_vec (score_vec),
      .id_vec    (id_vec),
      .gather    (gather)
   );

   always_comb begin
      status     = ST_NOT_FOUND;
      rank       = '0;
      out_score  = '0;
      out_id     = '0;
      count_next = count_ff;
      unique case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               status     = ST_OK;
               rank       = RANK_W'(gather.pos + COUNT_W'(1));
               count_next = count_ff + COUNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (gather.hit) begin
               status     = ST_OK;
               rank       = RANK_W'(gather.pos + COUNT_W'(1));
               count_next = count_ff - COUNT_W'(1);
            end
         end
         OP_RANK: begin
            if (gather.hit) begin
               status = ST_OK;
               rank   = RANK_W'(gather.pos + COUNT_W'(1));
            end
         end
         OP_AT_RANK: begin
            if (gather.pick) begin
               status    = ST_OK;
               rank      = qrank_ff;
               out_score = gather.score;
               out_id    = gather.id;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      score_in      = score_ff;
      id_in         = id_ff;
      qrank_in      = qrank_ff;
      count_in      = count_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      unique case (state_ff)
         S_IDLE: ;
         S_CMP:  state_in = S_UPD;
         S_UPD: begin
            if (finish) begin
               state_in      = S_IDLE;
               count_in      = count_next;
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = status;
               rsp_tdata_in  = RSP_DATA_W'({RANK_W'(count_next), out_id, out_score, rank});
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (accept) begin
         state_in = S_CMP;
         op_in    = op_type'(req_tuser);
         score_in = req_tdata[KEY_W-1:0];
         id_in    = req_tdata[2*KEY_W-1:KEY_W];
         qrank_in = req_tdata[2*KEY_W+RANK_W-1:2*KEY_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      op_ff        <= op_in;
      score_ff     <= score_in;
      id_ff        <= id_in;
      qrank_ff     <= qrank_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_full_report : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL) |->
         (rsp_tdata[RANK_W-1:0] == '0) &&
         (rsp_tdata[2*KEY_W+2*RANK_W-1:2*KEY_W+RANK_W] == RANK_W'(CAPACITY)))
      else $error("full response with rank or wrong total");

   a_ok_has_rank : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_OK) |-> (rsp_tdata[RANK_W-1:0] != '0))
      else $error("ok response without a rank");

   a_accept_compares : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CMP) && !req_tready)
      else $error("accepted request did not enter compare");

endmodule
